[src/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/mse_pkg.sv]
// Types and constants for the MIPS subset execute unit.
// No dependencies.
`timescale 1ns / 1ps

package mse_pkg;

    localparam int unsigned REG_W  = 32;
    localparam int unsigned RIDX_W = 5;
    localparam int unsigned PC_W   = 14;
    localparam int unsigned CFG_W  = 17;
    localparam int unsigned IN_W   = 56;
    localparam int unsigned OUT_W  = 88;

    localparam logic signed [REG_W-1:0] TARGET_MIN = 32'sd1;
    localparam logic signed [REG_W-1:0] TARGET_MAX = 32'sd16384;

    typedef enum logic [3:0] {
        OP_NOP  = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_BEQ  = 4'd4,
        OP_BNE  = 4'd5,
        OP_SLT  = 4'd6,
        OP_J    = 4'd7,
        OP_LW   = 4'd8,
        OP_SW   = 4'd9,
        OP_ADDI = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_ZERO_REG   = 3'd1,
        STS_ADDR_HIGH  = 3'd2,
        STS_BELOW_BASE = 3'd3,
        STS_MISALIGNED = 3'd4,
        STS_BAD_TARGET = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [PC_W-1:0]   npc;
        logic              do_reg;
        logic [REG_W-1:0]  value;
        logic              do_mem;
        logic              load;
    } exec_res_t;

endpackage

[src/mips_subset_execute_unit.sv]
// Execute unit for a ten-operation MIPS subset: register file, data memory, pc, counter.
// Depends on mse_pkg and assert_macros.svh.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  cfg      | in  | cfg_wr_en          | cfg_wr_data: data_base
//  s        | in  | s_tvalid/s_tready  | s_tdata: op, first_reg, second_reg, third_reg, imm
//  m        | out | m_tvalid/m_tready  | m_tdata: status .. cycle_total
//
// Register reads happen at accept; execute follows, and commit loads the result register.
// Non-load items issue one per cycle unless stalled; lw adds S_LOAD for its memory read.
// After reset a clearing pass zeroes all 2**(ADDR_BITS-2) data memory words; s_tready is low.
// A full result register that is not taken holds the item in execute and stops input.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mips_subset_execute_unit
    import mse_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,   // data_base
    input  logic              s_tvalid,
    output logic              s_tready,
    // [3:0] op, [8:4] first_reg, [13:9] second_reg, [18:14] third_reg,
    // [50:19] immediate, [55:51] zero
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [2:0] status, [16:3] next_pc, [17] reg_written, [22:18] written_index,
    // [54:23] written_value, [55] mem_written, [87:56] cycle_total
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int WIDX_W = ADDR_BITS - 2;
    localparam int WORDS  = 1 << WIDX_W;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  data_base_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [REG_W-1:0]  cyc_reg;
    logic [WIDX_W-1:0] clr_idx_reg;

    logic [3:0]               op_reg;
    logic [RIDX_W-1:0]        ra_reg;
    logic signed [REG_W-1:0]  imm_reg;

    logic [REG_W-1:0] rf_mem [32];
    logic [31:0]      rf_valid_reg;
    logic [REG_W-1:0] rd_a_reg, rd_b_reg;
    logic             ok_a_reg, ok_b_reg, fwd_a_reg, fwd_b_reg;

    logic [REG_W-1:0] dm_mem [WORDS];
    logic [REG_W-1:0] dm_rdata_reg;

    logic              m_valid_reg;
    status_t           out_status_reg;
    logic [PC_W-1:0]   out_pc_reg;
    logic              out_rw_reg;
    logic [RIDX_W-1:0] out_widx_reg;
    logic [REG_W-1:0]  out_wval_reg;
    logic              out_mw_reg;
    logic [REG_W-1:0]  out_cyc_reg;

    logic [3:0]        in_op;
    logic [RIDX_W-1:0] in_first, in_second, in_third, rd_a_addr;
    logic              accept, commit, out_free;

    logic [REG_W-1:0]  opnd_a, opnd_b;
    logic signed [33:0] addr;
    logic [WIDX_W-1:0] word_idx;
    exec_res_t         ex_res, res;
    logic [PC_W-1:0]   seq_pc;
    logic [REG_W-1:0]  cyc_next;
    logic              rf_we, dm_we;
    logic [WIDX_W-1:0] dm_waddr;
    logic [REG_W-1:0]  dm_wdata, prod;
    logic signed [REG_W-1:0] tgt;

    assign in_op     = s_tdata[3:0];
    assign in_first  = s_tdata[8:4];
    assign in_second = s_tdata[13:9];
    assign in_third  = s_tdata[18:14];

    // port A carries the second source for ALU ops, otherwise first_reg
    assign rd_a_addr = (in_op == OP_ADD || in_op == OP_SUB || in_op == OP_MUL ||
                        in_op == OP_SLT) ? in_third : in_first;

    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // control
    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == WIDX_W'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ex_res.load)
                begin
                    state_next = S_LOAD;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    s_tready   = 1'b1;
                    state_next = s_tvalid ? S_EXEC : S_IDLE;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    s_tready   = 1'b1;
                    state_next = s_tvalid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // operands with bypass of the write committed in the accept cycle
    assign opnd_a = fwd_a_reg ? out_wval_reg : (ok_a_reg ? rd_a_reg : '0);
    assign opnd_b = fwd_b_reg ? out_wval_reg : (ok_b_reg ? rd_b_reg : '0);

    assign seq_pc   = pc_reg + PC_W'(1);
    assign addr     = {{2{opnd_b[REG_W-1]}}, opnd_b} + {{2{imm_reg[REG_W-1]}}, imm_reg};
    assign word_idx = addr[ADDR_BITS-1:2];
    assign prod     = opnd_b * opnd_a;
    assign tgt      = imm_reg - 32'sd1;

    always_comb
    begin
        ex_res        = '0;
        ex_res.status = STS_OK;
        ex_res.npc    = seq_pc;
        case (op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI:
            begin
                if (ra_reg == '0)
                begin
                    ex_res.status = STS_ZERO_REG;
                end
                else
                begin
                    ex_res.do_reg = 1'b1;
                    case (op_reg)
                        OP_ADD:  ex_res.value = opnd_b + opnd_a;
                        OP_SUB:  ex_res.value = opnd_b - opnd_a;
                        OP_MUL:  ex_res.value = prod;
                        OP_SLT:  ex_res.value = REG_W'($signed(opnd_b) < $signed(opnd_a));
                        default: ex_res.value = opnd_b + $unsigned(imm_reg);
                    endcase
                end
            end
            OP_BEQ, OP_BNE, OP_J:
            begin
                if (op_reg == OP_J || ((op_reg == OP_BEQ) == (opnd_a == opnd_b)))
                begin
                    if (imm_reg < TARGET_MIN || imm_reg > TARGET_MAX)
                    begin
                        ex_res.status = STS_BAD_TARGET;
                    end
                    else
                    begin
                        ex_res.npc = tgt[PC_W-1:0];
                    end
                end
            end
            OP_LW, OP_SW:
            begin
                if (op_reg == OP_LW && ra_reg == '0)
                begin
                    ex_res.status = STS_ZERO_REG;
                end
                else if (!addr[33] && (|addr[32:ADDR_BITS]))
                begin
                    ex_res.status = STS_ADDR_HIGH;
                end
                else if (addr[33] || (addr[32:0] < {16'b0, data_base_reg}))
                begin
                    ex_res.status = STS_BELOW_BASE;
                end
                else if (|addr[1:0])
                begin
                    ex_res.status = STS_MISALIGNED;
                end
                else if (op_reg == OP_LW)
                begin
                    ex_res.load = 1'b1;
                end
                else
                begin
                    ex_res.do_mem = 1'b1;
                    ex_res.value  = opnd_a;
                end
            end
            default:
            begin
                ex_res.status = STS_OK;
            end
        endcase
    end

    always_comb
    begin
        res = ex_res;
        if (state_reg == S_LOAD)
        begin
            res        = '0;
            res.status = STS_OK;
            res.npc    = seq_pc;
            res.do_reg = 1'b1;
            res.value  = dm_rdata_reg;
        end
    end

    assign cyc_next = (op_reg >= OP_ADD && op_reg <= OP_ADDI && cyc_reg != '1)
                      ? cyc_reg + REG_W'(1) : cyc_reg;

    assign rf_we    = commit && res.status == STS_OK && res.do_reg;
    assign dm_we    = (state_reg == S_CLEAR) || (commit && res.status == STS_OK && res.do_mem);
    assign dm_waddr = (state_reg == S_CLEAR) ? clr_idx_reg : word_idx;
    assign dm_wdata = (state_reg == S_CLEAR) ? '0 : res.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            data_base_reg <= '0;
            pc_reg        <= '0;
            cyc_reg       <= '0;
            rf_valid_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + WIDX_W'(1);
            end
            if (cfg_wr_en)
            begin
                data_base_reg <= cfg_wr_data;
            end
            if (commit)
            begin
                cyc_reg <= cyc_next;
                if (res.status == STS_OK)
                begin
                    pc_reg <= res.npc;
                end
            end
            if (rf_we)
            begin
                rf_valid_reg[ra_reg] <= 1'b1;
            end
            if (commit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input register and register file
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            ra_reg    <= in_first;
            imm_reg   <= s_tdata[50:19];
            rd_a_reg  <= rf_mem[rd_a_addr];
            rd_b_reg  <= rf_mem[in_second];
            ok_a_reg  <= rf_valid_reg[rd_a_addr];
            ok_b_reg  <= rf_valid_reg[in_second];
            fwd_a_reg <= rf_we && (ra_reg == rd_a_addr);
            fwd_b_reg <= rf_we && (ra_reg == in_second);
        end
        if (rf_we)
        begin
            rf_mem[ra_reg] <= res.value;
        end
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && ex_res.load)
        begin
            dm_rdata_reg <= dm_mem[word_idx];
        end
        if (dm_we)
        begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_status_reg <= res.status;
            out_pc_reg     <= (res.status == STS_OK) ? res.npc : pc_reg;
            out_rw_reg     <= rf_we;
            out_widx_reg   <= rf_we ? ra_reg : '0;
            out_wval_reg   <= rf_we ? res.value : '0;
            out_mw_reg     <= res.status == STS_OK && res.do_mem;
            out_cyc_reg    <= cyc_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_cyc_reg, out_mw_reg, out_wval_reg, out_widx_reg, out_rw_reg,
                       out_pc_reg, out_status_reg};

    `ASSERT_IMPLIES(a_one_write, clk, rst_n, rf_we, !dm_we)
    `ASSERT_IMPLIES(a_fail_no_write, clk, rst_n, commit && res.status != STS_OK, !rf_we && !dm_we)
    `ASSERT_NEXT(a_commit_valid, clk, rst_n, commit, m_valid_reg)
    `ASSERT_NEXT(a_pc_hold, clk, rst_n, !commit, $stable(pc_reg))

endmodule
